// ===== hw/rtl/adg_pkg.sv =====
// Shared types, constants and helper functions for the dependency graph block.
// Used by adg_row_mem, adg_ctrl and acyclic_dependency_graph; depends on nothing.
`timescale 1ns / 1ps

package adg_pkg;

    localparam int NODES   = 32;
    localparam int ADDR_W  = $clog2(NODES);
    localparam int IDX_W   = 5;
    localparam int MASK_W  = 32;
    localparam int CNT_W   = 5;
    localparam int CNT_MAX = 31;

    typedef logic [NODES-1:0] row_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_COUNT  = 2'd1,
        ACT_CHECK  = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef struct packed {
        action_t           action;
        logic [IDX_W-1:0]  node;
        logic [IDX_W-1:0]  dependency;
        logic [MASK_W-1:0] approved_mask;
    } adg_in_t;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] reach_count;
    } adg_out_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        row_t              wr_data;
        logic              clr;
    } mem_req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctrl_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_WALK,
        ST_STEP,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_DONE
    } state_t;

    function automatic logic idx_ok(logic [IDX_W-1:0] idx);
        return 32'(idx) < NODES;
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(logic [IDX_W-1:0] idx);
        return ADDR_W'(idx);
    endfunction

    function automatic row_t one_hot(logic [ADDR_W-1:0] a);
        row_t r;
        r    = '0;
        r[a] = 1'b1;
        return r;
    endfunction

    // Nodes beyond the mask width are never approved.
    function automatic row_t approve_ext(logic [MASK_W-1:0] m);
        row_t r;
        r = '0;
        for (int i = 0; i < NODES && i < MASK_W; i++) begin
            r[i] = m[i];
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] lowest(row_t v);
        logic [ADDR_W-1:0] a;
        a = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (v[i]) begin
                a = ADDR_W'(i);
            end
        end
        return a;
    endfunction

    // Population count, saturated to the result field.
    function automatic logic [CNT_W-1:0] pop_sat(row_t v);
        logic [ADDR_W:0] c;
        c = '0;
        for (int i = 0; i < NODES; i++) begin
            c = c + (ADDR_W + 1)'(v[i]);
        end
        if (32'(c) > CNT_MAX) begin
            return CNT_W'(CNT_MAX);
        end
        return CNT_W'(c);
    endfunction

endpackage

// ===== hw/rtl/acyclic_dependency_graph.sv =====
// Top level of the acyclic dependency graph block: item handshakes and result register.
// Instantiates adg_ctrl and adg_row_mem; depends on adg_pkg.
`timescale 1ns / 1ps

// The block keeps a NODES-by-NODES dependency matrix (row n, bit d: n depends on d),
// all zero after reset, in a row memory with a registered read. Each item carries one
// action and yields exactly one result item. Insert first walks everything reachable
// from the dependency; when the node shows up there the edge is refused (ok = 0) and
// the matrix is left alone, otherwise the node's row is read and written back with
// the new bit. An insert with an out-of-range index is refused without a walk. Self
// edges are stored and accepted but every walk ignores them. Count walks from the
// node and returns the saturated number of distinct reachable nodes. Check compares
// the node's direct dependencies with approved_mask. Clear drops the row valid bits,
// so it completes in one step. Each node reached by a walk costs one read of the
// single memory read port followed by the merge of that row. One item is worked on
// at a time: req_stall is high from acceptance until the result moves into the
// output register, and the next item is taken while that result still waits on
// rsp_stall.
module acyclic_dependency_graph
    import adg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  adg_in_t  req_item,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output adg_out_t rsp_item
);

    mem_req_t   mem_req;
    row_t       rd_row;
    ctrl_stat_t stat;
    adg_out_t   result;
    logic       done_ack;

    logic       rsp_valid_reg, rsp_valid_next;
    adg_out_t   rsp_item_reg, rsp_item_next;

    adg_row_mem u_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mem_req),
        .rd_row (rd_row)
    );

    adg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_item  (req_item),
        .done_ack  (done_ack),
        .rd_row    (rd_row),
        .mem_req   (mem_req),
        .stat      (stat),
        .result    (result)
    );

    // Take new items only while the sequencer is idle.
    assign req_stall = !stat.idle;

    // Move a finished result into the output register once that slot is free or
    // being emptied this cycle.
    assign done_ack = stat.done && (!rsp_valid_reg || !rsp_stall);

    always_comb begin
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        if (done_ack) begin
            rsp_valid_next = 1'b1;
            rsp_item_next  = result;
        end else if (!rsp_stall) begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end else begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

// ===== hw/rtl/adg_row_mem.sv =====
// Edge matrix storage: one row per node, one write and one registered read per cycle.
// Row valid bits give the all-zero reset and the whole-matrix clear. Depends on adg_pkg.
`timescale 1ns / 1ps

module adg_row_mem
    import adg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output row_t     rd_row
);

    row_t             mem [NODES];
    logic [NODES-1:0] row_vld_reg;
    row_t             rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (req.clr) begin
                row_vld_reg <= '0;
            end else if (req.wr_en) begin
                row_vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_vld_reg <= row_vld_reg[req.rd_addr];
            end
        end
    end

    // A row never written since reset or clear reads as zero.
    assign rd_row = rd_vld_reg ? rd_data_reg : '0;

`ifndef ASSERT_OFF
    a_no_wr_on_clr: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.clr))
        else $error("row write coincides with matrix clear");

    a_no_rd_wr_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        (req.wr_en && req.rd_en) |-> (req.wr_addr != req.rd_addr))
        else $error("read and write of the same row in one cycle");
`endif

endmodule

// ===== hw/rtl/adg_ctrl.sv =====
// Sequencer for the graph actions: walks reachability one row read at a time and
// does the read-modify-write for edge insert. Depends on adg_pkg.
`timescale 1ns / 1ps

module adg_ctrl
    import adg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  adg_in_t    req_item,
    input  logic       done_ack,
    input  row_t       rd_row,
    output mem_req_t   mem_req,
    output ctrl_stat_t stat,
    output adg_out_t   result
);

    state_t            state_reg, state_next;
    adg_in_t           item_reg, item_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic              start_ok_reg, start_ok_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    row_t              reach_reg, reach_next;
    row_t              pending_reg, pending_next;
    logic              ok_reg, ok_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [IDX_W-1:0]  start_idx;
    row_t              row_clean;
    row_t              start_bit;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            reach_reg   <= '0;
            pending_reg <= '0;
        end else begin
            state_reg   <= state_next;
            reach_reg   <= reach_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk) begin
        item_reg     <= item_next;
        start_reg    <= start_next;
        start_ok_reg <= start_ok_next;
        cur_reg      <= cur_next;
        ok_reg       <= ok_next;
        count_reg    <= count_next;
    end

    // Walks for insert start at the dependency, all others at the node.
    assign start_idx = (req_item.action == ACT_INSERT) ? req_item.dependency : req_item.node;
    assign start_bit = start_ok_reg ? one_hot(start_reg) : '0;

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        start_next    = start_reg;
        start_ok_next = start_ok_reg;
        cur_next      = cur_reg;
        reach_next    = reach_reg;
        pending_next  = pending_reg;
        ok_next       = ok_reg;
        count_next    = count_reg;
        row_clean     = '0;
        mem_req       = '0;
        stat.idle     = 1'b0;
        stat.done     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                stat.idle = 1'b1;
                if (req_valid) begin
                    item_next     = req_item;
                    start_next    = to_addr(start_idx);
                    start_ok_next = idx_ok(start_idx);
                    ok_next       = 1'b1;
                    count_next    = '0;
                    priority if (req_item.action == ACT_CLEAR) begin
                        mem_req.clr = 1'b1;
                        state_next  = ST_DONE;
                    end else if (req_item.action == ACT_INSERT &&
                                 (!idx_ok(req_item.node) || !idx_ok(req_item.dependency))) begin
                        ok_next    = 1'b0;
                        state_next = ST_DONE;
                    end else if (req_item.action == ACT_INSERT &&
                                 req_item.node == req_item.dependency) begin
                        state_next = ST_RMW_RD;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = start_reg;
                state_next      = ST_LOAD;
            end
            ST_LOAD: begin
                // Drop the self edge; an out-of-range start has no edges.
                row_clean = start_ok_reg ? (rd_row & ~one_hot(start_reg)) : '0;
                if (item_reg.action == ACT_CHECK) begin
                    ok_next    = ((row_clean & ~approve_ext(item_reg.approved_mask)) == '0);
                    state_next = ST_DONE;
                end else begin
                    reach_next   = row_clean;
                    pending_next = row_clean;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK: begin
                if (pending_reg == '0) begin
                    if (item_reg.action == ACT_COUNT) begin
                        count_next = pop_sat(reach_reg & ~start_bit);
                        state_next = ST_DONE;
                    end else if (reach_reg[to_addr(item_reg.node)]) begin
                        // Node reachable from the dependency: the edge would close a cycle.
                        ok_next    = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_RMW_RD;
                    end
                end else begin
                    cur_next        = lowest(pending_reg);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = cur_next;
                    pending_next    = pending_reg & ~one_hot(cur_next);
                    state_next      = ST_STEP;
                end
            end
            ST_STEP: begin
                row_clean    = rd_row & ~one_hot(cur_reg);
                pending_next = pending_reg | (row_clean & ~reach_reg);
                reach_next   = reach_reg | row_clean;
                state_next   = ST_WALK;
            end
            ST_RMW_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = to_addr(item_reg.node);
                state_next      = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = to_addr(item_reg.node);
                mem_req.wr_data = rd_row | one_hot(to_addr(item_reg.dependency));
                ok_next         = 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                stat.done = 1'b1;
                if (done_ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.ok          = ok_reg;
    assign result.reach_count = count_reg;

`ifndef ASSERT_OFF
    a_rmw_reads_first: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> ($past(mem_req.rd_en) && $past(mem_req.rd_addr) == mem_req.wr_addr))
        else $error("row write without a read of the same row one cycle before");

    a_pending_in_reach: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~reach_reg) == '0)
        else $error("pending node outside the reach set");
`endif

endmodule

// ===== bench/tb_acyclic_dependency_graph.sv =====
// Self-checking testbench for the acyclic dependency graph block.
// Drives items with random gaps and stalls and checks every result against a local predictor or the table.
// Depends on adg_pkg and acyclic_dependency_graph.
`timescale 1ns / 1ps

module tb_acyclic_dependency_graph;
    import adg_pkg::*;

    // The random part follows the directed table and the opening full-length chain.
    localparam int RANDOM_ITEMS    = 1730;
    // Margin after the last result for the longest item, an insert whose walk reaches the most nodes.
    localparam int DRAIN_CYCLES    = 80;
    // Receiver hold-off, long enough that the block stops taking items.
    localparam int HOLD_OFF_CYCLES = 300;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    adg_in_t  req_item  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    adg_out_t rsp_item;

    acyclic_dependency_graph dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always #10 clk = ~clk;

    // One row of the directed table; want is only used where known is set.
    typedef struct {
        adg_in_t  item;
        bit       known;
        adg_out_t want;
    } dir_row_t;

    // Predictor state: bit d of row n means node n depends on node d.
    row_t        dep_rows [NODES] = '{default: '0};
    // Results owed by the block, oldest first.
    adg_out_t    pending_results [$];
    // Items generated ahead of time (chains), sent before any new random item.
    adg_in_t     queued_items [$];
    // Topological order for the current graph: well-formed inserts point down this order.
    int unsigned node_order [NODES];

    int unsigned mismatches      = 0;
    int unsigned results_taken   = 0;
    int unsigned refused_inserts = 0;
    int unsigned full_reach      = 0;
    int unsigned action_tally [4] = '{default: 0};
    int unsigned send_calm       = 0;
    int unsigned recv_calm       = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Direct dependencies of a node; self edges are stored but never followed.
    function automatic row_t direct_deps(logic [IDX_W-1:0] n);
        row_t r;
        if (32'(n) >= NODES) begin
            return '0;
        end
        r    = dep_rows[n];
        r[n] = 1'b0;
        return r;
    endfunction

    // Transitive closure from one node; NODES rounds always reach the fixed point.
    function automatic row_t reachable_set(logic [IDX_W-1:0] start);
        row_t seen;
        row_t grown;
        seen = direct_deps(start);
        repeat (NODES) begin
            grown = seen;
            for (int i = 0; i < NODES; i++) begin
                if (seen[i]) begin
                    grown |= direct_deps(IDX_W'(i));
                end
            end
            seen = grown;
        end
        return seen;
    endfunction

    // Apply one accepted item to the predicted graph and return its result.
    function automatic adg_out_t graph_apply(adg_in_t it);
        adg_out_t res;
        row_t     reach;
        res.ok          = 1'b1;
        res.reach_count = '0;
        case (it.action)
            ACT_INSERT: begin
                if (32'(it.node) >= NODES || 32'(it.dependency) >= NODES) begin
                    res.ok = 1'b0;
                end else begin
                    // Set the edge, then roll it back if the dependency now reaches the node.
                    dep_rows[it.node][it.dependency] = 1'b1;
                    reach = reachable_set(it.dependency);
                    if (it.dependency != it.node && reach[it.node]) begin
                        dep_rows[it.node][it.dependency] = 1'b0;
                        res.ok = 1'b0;
                    end
                end
            end
            ACT_COUNT: begin
                reach          = reachable_set(it.node);
                reach[it.node] = 1'b0;
                res.reach_count = ($countones(reach) > CNT_MAX) ? CNT_W'(CNT_MAX)
                                                                 : CNT_W'($countones(reach));
            end
            ACT_CHECK: begin
                // Nodes above the mask width zero-extend to "not approved".
                res.ok = ((direct_deps(it.node) & ~row_t'(it.approved_mask)) == '0);
            end
            ACT_CLEAR: begin
                dep_rows = '{default: '0};
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    function automatic adg_in_t make_item(action_t a, int unsigned n, int unsigned d,
                                          logic [MASK_W-1:0] m);
        adg_in_t it;
        it.action        = a;
        it.node          = IDX_W'(n);
        it.dependency    = IDX_W'(d);
        it.approved_mask = m;
        return it;
    endfunction

    function automatic dir_row_t dir_row(action_t a, int unsigned n, int unsigned d,
                                         logic [MASK_W-1:0] m, bit known, bit ok,
                                         int unsigned cnt);
        dir_row_t r;
        r.item             = make_item(a, n, d, m);
        r.known            = known;
        r.want.ok          = ok;
        r.want.reach_count = CNT_W'(cnt);
        return r;
    endfunction

    function automatic void shuffle_order();
        int unsigned j;
        int unsigned t;
        for (int i = 0; i < NODES; i++) begin
            node_order[i] = i;
        end
        for (int i = NODES - 1; i > 0; i--) begin
            j             = $urandom_range(0, i);
            t             = node_order[i];
            node_order[i] = node_order[j];
            node_order[j] = t;
        end
    endfunction

    // Clear, build a chain of len nodes in a fresh random order, count both ends,
    // then try to close the loop, which must be refused.
    function automatic void queue_chain(int unsigned len);
        shuffle_order();
        queued_items.push_back(make_item(ACT_CLEAR, $urandom, $urandom, $urandom));
        for (int i = 1; i < len; i++) begin
            queued_items.push_back(make_item(ACT_INSERT, node_order[i], node_order[i - 1],
                                             $urandom));
        end
        queued_items.push_back(make_item(ACT_COUNT, node_order[len - 1], $urandom, $urandom));
        queued_items.push_back(make_item(ACT_COUNT, node_order[0], $urandom, $urandom));
        queued_items.push_back(make_item(ACT_INSERT, node_order[0], node_order[len - 1],
                                         $urandom));
    endfunction

    // Mostly inserts that respect the current order, so the graph grows deep;
    // the rest are random inserts (which can close cycles), self edges, counts,
    // checks with masks built around the real row, and the odd clear.
    function automatic adg_in_t rand_item();
        adg_in_t     it;
        int unsigned pick;
        int unsigned hi;
        int unsigned lo;
        it   = make_item(ACT_COUNT, $urandom, $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            hi            = $urandom_range(1, NODES - 1);
            lo            = $urandom_range(0, hi - 1);
            it.action     = ACT_INSERT;
            it.node       = IDX_W'(node_order[hi]);
            it.dependency = IDX_W'(node_order[lo]);
        end else if (pick < 55) begin
            it.action = ACT_INSERT;
        end else if (pick < 58) begin
            it.action     = ACT_INSERT;
            it.dependency = it.node;
        end else if (pick < 78) begin
            it.action = ACT_COUNT;
        end else if (pick < 98) begin
            it.action = ACT_CHECK;
            case ($urandom_range(0, 3))
                0, 1: it.approved_mask = MASK_W'(dep_rows[it.node]) | ($urandom & $urandom);
                2: begin
                    it.approved_mask = MASK_W'(dep_rows[it.node]) | $urandom;
                    it.approved_mask[$urandom_range(0, MASK_W - 1)] = 1'b0;
                end
                default: it.approved_mask = $urandom;
            endcase
        end else begin
            it.action = ACT_CLEAR;
            shuffle_order();
        end
        return it;
    endfunction

    // Per-item random wait, with occasional runs of back-to-back items.
    function automatic int unsigned wait_draw(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item after a random gap, hold it until taken, then log what it owes.
    task automatic send_item(input adg_in_t it, input bit known, input adg_out_t want);
        int unsigned gap;
        adg_out_t    predicted;
        gap = wait_draw(send_calm);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do @(posedge clk); while (req_stall);
        // Advance the predictor for every row, typed-in or not.
        predicted = graph_apply(it);
        if (known) begin
            predicted = want;
        end
        pending_results.push_back(predicted);
        action_tally[it.action]++;
        if (it.action == ACT_INSERT && !predicted.ok) begin
            refused_inserts++;
        end
        if (it.action == ACT_COUNT && predicted.reach_count == CNT_W'(CNT_MAX)) begin
            full_reach++;
        end
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    initial begin
        dir_row_t table_rows [$];
        adg_in_t  it;
        shuffle_order();

        // Directed table: action, node, dependency, mask, known, ok, count.
        // Graph built here: 31 -> 0 -> 1, then 2 -> 31 and the cross edge 2 -> 0.
        table_rows.push_back(dir_row(ACT_COUNT,   0,  0, 32'h0000_0000, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_CHECK,  31, 31, 32'h0000_0000, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_INSERT, 31,  0, 32'hFFFF_FFFF, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_INSERT,  0, 31, 32'h0000_0000, 1, 0, 0)); // loop of two nodes
        table_rows.push_back(dir_row(ACT_INSERT,  7,  7, 32'h5555_5555, 1, 1, 0)); // self edge
        table_rows.push_back(dir_row(ACT_COUNT,   7,  0, 32'hAAAA_AAAA, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_CHECK,   7,  0, 32'h0000_0000, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_CHECK,  31,  0, 32'h0000_0000, 1, 0, 0));
        table_rows.push_back(dir_row(ACT_CHECK,  31,  0, 32'h0000_0001, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_CHECK,  31,  0, 32'hFFFF_FFFE, 1, 0, 0));
        table_rows.push_back(dir_row(ACT_INSERT,  0,  1, 32'h0000_0000, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_INSERT,  1, 31, 32'h0000_0000, 1, 0, 0)); // loop of three nodes
        table_rows.push_back(dir_row(ACT_COUNT,  31, 31, 32'h0000_0000, 1, 1, 2));
        table_rows.push_back(dir_row(ACT_INSERT,  2, 31, 32'h0000_0000, 0, 0, 0));
        table_rows.push_back(dir_row(ACT_INSERT,  2,  0, 32'h0000_0000, 0, 0, 0)); // cross edge
        table_rows.push_back(dir_row(ACT_COUNT,   2,  0, 32'h0000_0000, 0, 0, 0));
        table_rows.push_back(dir_row(ACT_CHECK,   2,  0, 32'hFFFF_FFFF, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_CHECK,   2,  0, 32'h8000_0000, 0, 0, 0));
        table_rows.push_back(dir_row(ACT_INSERT, 31, 31, 32'h0000_0000, 1, 1, 0)); // self edge
        table_rows.push_back(dir_row(ACT_COUNT,  31,  0, 32'h0000_0000, 0, 0, 0));
        table_rows.push_back(dir_row(ACT_CLEAR,  31, 31, 32'hFFFF_FFFF, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_COUNT,  31,  0, 32'h0000_0000, 1, 1, 0));
        table_rows.push_back(dir_row(ACT_CHECK,   2,  0, 32'h0000_0000, 1, 1, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i]) begin
            send_item(table_rows[i].item, table_rows[i].known, table_rows[i].want);
        end
        wait_drained();

        // Open with a chain through every node: the far end reaches all others.
        queue_chain(NODES);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (queued_items.size() == 0) begin
                if ($urandom_range(0, 99) == 0) begin
                    queue_chain($urandom_range(2, NODES));
                end else begin
                    queued_items.push_back(rand_item());
                end
            end
            it = queued_items.pop_front();
            send_item(it, 1'b0, '0);
            // Pause mid-run with the block fully drained.
            if (n == RANDOM_ITEMS / 3) begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d inserts (%0d refused as cycles), %0d counts (%0d at full reach)",
                 action_tally[ACT_INSERT], refused_inserts, action_tally[ACT_COUNT], full_reach);
        $display("covered %0d checks and %0d clears; %0d results compared, %0d mismatches",
                 action_tally[ACT_CHECK], action_tally[ACT_CLEAR], results_taken, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", results_taken, msg);
        mismatches++;
    endtask

    initial begin
        int unsigned stall;
        adg_out_t    want;
        wait (rst_n === 1'b1);
        forever begin
            stall = wait_draw(recv_calm);
            // Hold off long twice while the sender keeps offering, so input stalls too.
            if (results_taken == 250 || results_taken == 1200) begin
                stall = HOLD_OFF_CYCLES;
            end
            if (stall != 0) begin
                rsp_stall <= 1'b1;
                repeat (stall) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            do @(posedge clk); while (!rsp_valid);
            results_taken++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                want = pending_results.pop_front();
                if (rsp_item.ok !== want.ok) begin
                    report_mismatch($sformatf("ok got %0b want %0b", rsp_item.ok, want.ok));
                end
                if (rsp_item.reach_count !== want.reach_count) begin
                    report_mismatch($sformatf("reach_count got %0d want %0d",
                                              rsp_item.reach_count, want.reach_count));
                end
            end
        end
    end

    // Hard stop at several times the slowest correct run.
    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule
